/* design/bpc_pkg.sv */
package bpc_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int PIN_BITS = 4;
  localparam int BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int STAMP_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int BUTTON_ID_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN = 1'b1;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] CLICK_MIN_RESET = 16'd20;

  localparam logic KIND_CLICK = 1'b0;
  localparam logic KIND_LONG = 1'b1;

  typedef struct packed {
    logic [PIN_BITS-1:0] pin_levels;
    logic [STAMP_W-1:0] now_ms;
  } scan_t;

  typedef struct packed {
    logic [BUTTON_ID_W-1:0] button_id;
    logic event_kind;
    logic last_event;
  } press_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] fire;
    logic [NUM_BUTTONS-1:0] kind;
  } ev_t;

endpackage

/* design/bpc_eval.sv */
module bpc_eval import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 take,
  input  scan_t                scan,
  output ev_t                  ev
);

  logic [CFG_W-1:0] long_press_ms;
  logic [CFG_W-1:0] click_min_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
      click_min_ms <= CLICK_MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_PRESS: long_press_ms <= cfg_data;
        CFG_CLICK_MIN:  click_min_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    logic               held;
    logic               long_fired;
    logic [STAMP_W-1:0] press_stamp;
    logic               down;
    logic [STAMP_W-1:0] elapsed;
    logic               held_next;
    logic               long_fired_next;
    logic               stamp_load;
    logic               fire;
    logic               kind;

    if (g < PIN_BITS) begin : g_pin
      assign down = ~scan.pin_levels[g];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    assign elapsed = scan.now_ms - press_stamp;

    always_comb begin
      held_next = held;
      long_fired_next = long_fired;
      stamp_load = 1'b0;
      fire = 1'b0;
      kind = KIND_CLICK;
      if (down && !held) begin
        held_next = 1'b1;
        long_fired_next = 1'b0;
        stamp_load = 1'b1;
      end else if (down && held) begin
        if (!long_fired && (elapsed > STAMP_W'(long_press_ms))) begin
          long_fired_next = 1'b1;
          fire = 1'b1;
          kind = KIND_LONG;
        end
      end else if (!down && held) begin
        held_next = 1'b0;
        if (!long_fired && (elapsed > STAMP_W'(click_min_ms))) begin
          fire = 1'b1;
        end
      end
    end

    assign ev.fire[g] = fire;
    assign ev.kind[g] = kind;

    always_ff @(posedge clk) begin
      if (rst) begin
        held <= 1'b0;
        long_fired <= 1'b0;
      end else if (take) begin
        held <= held_next;
        long_fired <= long_fired_next;
      end
    end

    always_ff @(posedge clk) begin
      if (take && stamp_load) begin
        press_stamp <= scan.now_ms;
      end
    end
  end

endmodule

/* design/bpc_serial.sv */
module bpc_serial import bpc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   take,
  input  ev_t    ev,
  output logic   free,
  output logic   press_valid,
  input  logic   press_stall,
  output press_t press
);

  logic [NUM_BUTTONS-1:0] mask;
  logic [NUM_BUTTONS-1:0] kinds;
  logic [NUM_BUTTONS-1:0] pick;
  logic [NUM_BUTTONS-1:0] rest;
  logic [BTN_IDX_W-1:0]   pick_idx;
  logic                   can_load;
  logic                   pick_kind;

  assign can_load = !press_valid || !press_stall;
  assign pick = mask & (~mask + NUM_BUTTONS'(1));
  assign rest = mask & ~pick;
  assign free = (mask == '0) || (can_load && (rest == '0));
  assign pick_kind = |(pick & kinds);

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (pick[i]) begin
        pick_idx = BTN_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      press_valid <= 1'b0;
    end else begin
      if (take) begin
        mask <= ev.fire;
      end else if (can_load) begin
        mask <= rest;
      end
      if (can_load) begin
        press_valid <= (mask != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kinds <= ev.kind;
    end
    if (can_load && (mask != '0)) begin
      press.button_id <= BUTTON_ID_W'(pick_idx);
      press.event_kind <= pick_kind;
      press.last_event <= (rest == '0);
    end
  end

`ifndef SYNTH
  a_pending_shows: assert property (@(posedge clk) disable iff (rst)
    (mask != '0) |=> press_valid)
    else $error("Pending events did not reach the output register.");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    take |-> ((mask == '0) || ($countones(mask) == 1 && can_load)))
    else $error("New events loaded over undelivered ones.");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (can_load && (mask != '0) && (rest != '0)) |=> (mask != '0))
    else $error("Beat not marked last but no further event pending.");
`endif

endmodule

/* design/button_press_classifier_top.sv */
// Classifies each scan of the buttons into short clicks and long presses. A
// scan beat is taken whenever the internal event buffer is free, which is
// every cycle while scans cause at most one event each and the output is not
// stalled; a scan with several events holds the buffer while the single
// output register drains them, one event per beat unless stalled. The first
// event of a scan passes through the event mask and then the output register;
// events leave in ascending button order, the final one marked by last_event.
// Configuration writes are meant for idle periods only.
module button_press_classifier_top import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 scan_valid,
  output logic                 scan_stall,
  input  scan_t                scan,
  output logic                 press_valid,
  input  logic                 press_stall,
  output press_t               press
);

  logic  scan_reg_valid;
  scan_t scan_reg;
  logic  take;
  logic  free;
  ev_t   ev;

  assign take = scan_reg_valid && free;
  assign scan_stall = scan_reg_valid && !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_reg_valid <= 1'b0;
    end else if (!scan_stall) begin
      scan_reg_valid <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!scan_stall && scan_valid) begin
      scan_reg <= scan;
    end
  end

  bpc_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .scan      (scan_reg),
    .ev        (ev)
  );

  bpc_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .ev          (ev),
    .free        (free),
    .press_valid (press_valid),
    .press_stall (press_stall),
    .press       (press)
  );

endmodule
